>>> sv/assert_macros.svh
// Assertion macros shared by the segmented prime counter RTL.
// Needs a clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clk edge, off during reset.
`define SPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/spc_pkg.sv
// Shared constants for the segmented prime counter.
// No dependencies.
package spc_pkg;
    localparam int WINDOW_DEF          = 131072;
    localparam int BASE_LIMIT_DEF      = 65536;
    localparam int BASE_PRIMES_MAX_DEF = 8192;
    localparam int RANGE_W             = 31;
    localparam int COUNT_W             = 18;
    localparam int PRIME_W             = 16;
endpackage

>>> sv/segmented_prime_counter.sv
// Segmented prime counter: counts primes in [range_low, range_high] with a
// window bitmap memory sieved by a base prime table built after reset.
// After reset the base sieve runs first (clear of the composite map, then a
// read and test of each number and a mark of the multiples of each prime
// found); in_ready stays low until it ends. A query fills the window, then
// per sieving prime reads the list, squares the prime, stops once the square
// exceeds range_high, else takes the remainder of range_low and clears the
// prime's multiples, then counts the window. Items are handled one at a
// time; an out-of-range query skips fill and sieve and goes to the result.
`include "assert_macros.svh"

module segmented_prime_counter
#(
    parameter int WINDOW          = spc_pkg::WINDOW_DEF,
    parameter int BASE_LIMIT      = spc_pkg::BASE_LIMIT_DEF,
    parameter int BASE_PRIMES_MAX = spc_pkg::BASE_PRIMES_MAX_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [spc_pkg::RANGE_W-1:0] range_low,
    input  logic [spc_pkg::RANGE_W-1:0] range_high,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [spc_pkg::COUNT_W-1:0] prime_count,
    output logic                        range_error
);
    localparam int PW    = $clog2(BASE_PRIMES_MAX);
    localparam int WIDX  = $clog2(WINDOW);
    localparam int OFF_W = ((WIDX > spc_pkg::PRIME_W + 1) ? WIDX : spc_pkg::PRIME_W + 1) + 1;
    localparam int RW    = spc_pkg::RANGE_W;
    localparam int QW    = spc_pkg::PRIME_W;

    localparam logic [3:0] Q_IDLE  = 4'd0;
    localparam logic [3:0] Q_CHK   = 4'd1;
    localparam logic [3:0] Q_FILL  = 4'd2;
    localparam logic [3:0] Q_PREQ  = 4'd3;
    localparam logic [3:0] Q_PWAIT = 4'd4;
    localparam logic [3:0] Q_PSQ   = 4'd5;
    localparam logic [3:0] Q_PCHK  = 4'd6;
    localparam logic [3:0] Q_REM   = 4'd7;
    localparam logic [3:0] Q_MARK  = 4'd8;
    localparam logic [3:0] Q_CNT   = 4'd9;
    localparam logic [3:0] Q_OUT   = 4'd10;

    logic win_mem [WINDOW];
    logic win_q;

    logic [3:0]                 state_reg, state_next;
    logic [RW-1:0]              low_reg, high_reg;
    logic [WIDX-1:0]            span_reg, span_next;
    logic [WIDX-1:0]            idx_reg, idx_next;
    logic [WIDX-1:0]            ridx_reg, ridx_next;
    logic                       issue_reg, issue_next;
    logic                       rpend_reg, rpend_next;
    logic [PW:0]                k_reg, k_next;
    logic [QW-1:0]              p_reg, p_next;
    logic [2*QW-1:0]            sq_reg;
    logic [OFF_W-1:0]           off_reg, off_next;
    logic [spc_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic                       err_reg, err_next;

    logic                        base_ready;
    logic [PW:0]                 base_total;
    logic [QW-1:0]               list_data;
    logic                        rem_start;
    logic                        rem_done;
    logic [QW-1:0]               rem_val;
    logic                        win_we;
    logic                        win_wd;
    logic [WIDX-1:0]             win_wa;
    logic [RW:0]                 diff;
    logic [QW:0]                 adj;
    logic [RW:0]                 start_val;
    logic                        skip_bit;

    spc_base #(
        .BASE_LIMIT      (BASE_LIMIT),
        .BASE_PRIMES_MAX (BASE_PRIMES_MAX),
        .PW              (PW)
    ) u_base (
        .clk        (clk),
        .rst_n      (rst_n),
        .list_addr  (k_reg[PW-1:0]),
        .list_data  (list_data),
        .list_total (base_total),
        .ready      (base_ready)
    );

    spc_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (low_reg),
        .divisor   (p_reg),
        .done      (rem_done),
        .remainder (rem_val)
    );

    assign diff      = {1'b0, high_reg} - {1'b0, low_reg};
    assign adj       = (rem_val == '0) ? '0 : ({1'b0, p_reg} - {1'b0, rem_val});
    assign start_val = {1'b0, low_reg} + (RW+1)'(adj);
    assign skip_bit  = ((low_reg == '0) && (ridx_reg <= WIDX'(1)))
                       || ((low_reg == RW'(1)) && (ridx_reg == '0));

    always_comb
    begin
        state_next = state_reg;
        span_next  = span_reg;
        idx_next   = idx_reg;
        ridx_next  = ridx_reg;
        issue_next = issue_reg;
        rpend_next = 1'b0;
        k_next     = k_reg;
        p_next     = p_reg;
        off_next   = off_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        rem_start  = 1'b0;
        win_we     = 1'b0;
        win_wd     = 1'b0;
        win_wa     = idx_reg;
        unique case (state_reg)
            Q_IDLE:
            begin
                if (in_valid && base_ready)
                    state_next = Q_CHK;
            end
            Q_CHK:
            begin
                cnt_next = '0;
                idx_next = '0;
                k_next   = '0;
                if (diff[RW] || (diff >= (RW+1)'(WINDOW)))
                begin
                    err_next   = 1'b1;
                    state_next = Q_OUT;
                end
                else
                begin
                    err_next   = 1'b0;
                    span_next  = diff[WIDX-1:0];
                    state_next = Q_FILL;
                end
            end
            Q_FILL:
            begin
                win_we   = 1'b1;
                win_wd   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == span_reg)
                    state_next = Q_PREQ;
            end
            Q_PREQ:
            begin
                if (k_reg >= base_total)
                begin
                    idx_next   = '0;
                    issue_next = 1'b1;
                    state_next = Q_CNT;
                end
                else
                    state_next = Q_PWAIT;
            end
            Q_PWAIT:
            begin
                p_next     = list_data;
                state_next = Q_PSQ;
            end
            Q_PSQ:
            begin
                state_next = Q_PCHK;
            end
            Q_PCHK:
            begin
                if (sq_reg > (2*QW)'(high_reg))
                begin
                    idx_next   = '0;
                    issue_next = 1'b1;
                    state_next = Q_CNT;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = Q_REM;
                end
            end
            Q_REM:
            begin
                if (rem_done)
                begin
                    if (start_val <= (RW+1)'(p_reg))
                        off_next = OFF_W'({p_reg, 1'b0} - (QW+1)'(low_reg));
                    else
                        off_next = OFF_W'(adj);
                    state_next = Q_MARK;
                end
            end
            Q_MARK:
            begin
                if (off_reg <= OFF_W'(span_reg))
                begin
                    win_we   = 1'b1;
                    win_wd   = 1'b0;
                    win_wa   = off_reg[WIDX-1:0];
                    off_next = off_reg + OFF_W'(p_reg);
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = Q_PREQ;
                end
            end
            Q_CNT:
            begin
                if (issue_reg)
                begin
                    rpend_next = 1'b1;
                    ridx_next  = idx_reg;
                    idx_next   = idx_reg + 1'b1;
                    if (idx_reg == span_reg)
                        issue_next = 1'b0;
                end
                if (rpend_reg && win_q && !skip_bit)
                    cnt_next = cnt_reg + 1'b1;
                if (!issue_reg && !rpend_reg)
                    state_next = Q_OUT;
            end
            Q_OUT:
            begin
                if (out_ready)
                    state_next = Q_IDLE;
            end
            default:
            begin
                state_next = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            issue_reg <= 1'b0;
            rpend_reg <= 1'b0;
            k_reg     <= '0;
            cnt_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            rpend_reg <= rpend_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == Q_IDLE)
        begin
            low_reg  <= range_low;
            high_reg <= range_high;
        end
        span_reg <= span_next;
        idx_reg  <= idx_next;
        ridx_reg <= ridx_next;
        p_reg    <= p_next;
        off_reg  <= off_next;
        sq_reg   <= p_reg * p_reg;
        if (win_we)
            win_mem[win_wa] <= win_wd;
        win_q <= win_mem[idx_reg];
    end

    assign in_ready    = (state_reg == Q_IDLE) && base_ready;
    assign out_valid   = (state_reg == Q_OUT);
    assign prime_count = cnt_reg;
    assign range_error = err_reg;

    `SPC_ASSERT(a_err_zero, (out_valid && range_error) |-> (prime_count == '0),
        "error result with nonzero count")
    `SPC_ASSERT(a_one_item, !(in_ready && out_valid), "input taken while result pending")
    `SPC_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready,
        "ready stayed high after accept")
endmodule

>>> sv/spc_rem.sv
// Iterative remainder unit: dividend mod divisor, one quotient bit per cycle.
// Uses spc_pkg widths.
module spc_rem
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [spc_pkg::RANGE_W-1:0]     dividend,
    input  logic [spc_pkg::PRIME_W-1:0]     divisor,
    output logic                            done,
    output logic [spc_pkg::PRIME_W-1:0]     remainder
);
    localparam int CNT_W = $clog2(spc_pkg::RANGE_W + 1);

    logic [spc_pkg::RANGE_W-1:0] dvd_reg;
    logic [spc_pkg::PRIME_W-1:0] dvs_reg;
    logic [spc_pkg::PRIME_W:0]   rem_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [spc_pkg::PRIME_W:0]   shifted;

    assign shifted = {rem_reg[spc_pkg::PRIME_W-1:0], dvd_reg[spc_pkg::RANGE_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(spc_pkg::RANGE_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[spc_pkg::RANGE_W-2:0], 1'b0};
            if (shifted >= {1'b0, dvs_reg})
                rem_reg <= shifted - {1'b0, dvs_reg};
            else
                rem_reg <= shifted;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[spc_pkg::PRIME_W-1:0];
endmodule

>>> sv/spc_base.sv
// Base sieve after reset: composite map and ordered base prime list memories.
// Uses spc_pkg widths; list read port for the query sequencer.
module spc_base
#(
    parameter int BASE_LIMIT      = spc_pkg::BASE_LIMIT_DEF,
    parameter int BASE_PRIMES_MAX = spc_pkg::BASE_PRIMES_MAX_DEF,
    parameter int PW              = $clog2(BASE_PRIMES_MAX)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [PW-1:0]               list_addr,
    output logic [spc_pkg::PRIME_W-1:0] list_data,
    output logic [PW:0]                 list_total,
    output logic                        ready
);
    localparam int LW = $clog2(BASE_LIMIT);

    localparam logic [2:0] B_CLR  = 3'd0;
    localparam logic [2:0] B_RD   = 3'd1;
    localparam logic [2:0] B_TST  = 3'd2;
    localparam logic [2:0] B_SQ   = 3'd3;
    localparam logic [2:0] B_MARK = 3'd4;
    localparam logic [2:0] B_DONE = 3'd5;

    logic                        comp_mem [BASE_LIMIT];
    logic [spc_pkg::PRIME_W-1:0] list_mem [BASE_PRIMES_MAX];

    logic [2:0]      state_reg, state_next;
    logic [LW:0]     n_reg, n_next;
    logic [LW:0]     m_reg, m_next;
    logic [PW:0]     total_reg, total_next;
    logic [2*LW-1:0] sq_reg;
    logic            comp_q;
    logic            comp_we;
    logic            comp_wd;
    logic [LW-1:0]   comp_wa;
    logic            list_we;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        total_next = total_reg;
        comp_we    = 1'b0;
        comp_wd    = 1'b0;
        comp_wa    = n_reg[LW-1:0];
        list_we    = 1'b0;
        unique case (state_reg)
            B_CLR:
            begin
                comp_we = 1'b1;
                n_next  = n_reg + 1'b1;
                if (n_reg == (LW+1)'(BASE_LIMIT - 1))
                begin
                    n_next     = (LW+1)'(2);
                    state_next = B_RD;
                end
            end
            B_RD:
            begin
                if (n_reg >= (LW+1)'(BASE_LIMIT))
                    state_next = B_DONE;
                else
                    state_next = B_TST;
            end
            B_TST:
            begin
                if (comp_q)
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = B_RD;
                end
                else
                begin
                    if (total_reg < (PW+1)'(BASE_PRIMES_MAX))
                    begin
                        list_we    = 1'b1;
                        total_next = total_reg + 1'b1;
                    end
                    state_next = B_SQ;
                end
            end
            B_SQ:
            begin
                if (sq_reg < (2*LW)'(BASE_LIMIT))
                begin
                    m_next     = sq_reg[LW:0];
                    state_next = B_MARK;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = B_RD;
                end
            end
            B_MARK:
            begin
                if (m_reg < (LW+1)'(BASE_LIMIT))
                begin
                    comp_we = 1'b1;
                    comp_wd = 1'b1;
                    comp_wa = m_reg[LW-1:0];
                    m_next  = m_reg + n_reg;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = B_RD;
                end
            end
            B_DONE:
            begin
            end
            default:
            begin
                state_next = B_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLR;
            n_reg     <= '0;
            m_reg     <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            m_reg     <= m_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= n_reg[LW-1:0] * n_reg[LW-1:0];
        if (comp_we)
            comp_mem[comp_wa] <= comp_wd;
        comp_q <= comp_mem[n_reg[LW-1:0]];
        if (list_we)
            list_mem[total_reg[PW-1:0]] <= spc_pkg::PRIME_W'(n_reg);
        list_data <= list_mem[list_addr];
    end

    assign list_total = total_reg;
    assign ready      = (state_reg == B_DONE);
endmodule
